// ===== rtl/fpg_pkg.sv =====
`timescale 1ns / 1ps

package fpg_pkg;

   localparam int MAX_TRANSDUCERS = 512;

   localparam int INDEX_W   = 9;
   localparam int COORD_W   = 24;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 3;
   localparam int WAVES_W   = 32;
   localparam int PROD_W    = WAVES_W + ROOT_W;
   localparam int COUNT_W   = 10;
   localparam int AMP_W     = 17;
   localparam int PHASE_W   = 17;
   localparam int TURN_SHIFT = 36;
   localparam int FRAC_SHIFT = 20;
   localparam int CSR_DATA_W = 32;

   localparam int DIST_STAGES  = 3;
   localparam int PHASE_STAGES = 2;
   localparam int PIPE_LATENCY = DIST_STAGES + ROOT_W + PHASE_STAGES;

   localparam logic [AMP_W-1:0]   FULL_AMPLITUDE = AMP_W'(65536);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT    = COUNT_W'(MAX_TRANSDUCERS);
   localparam logic [PROD_W-1:0]  HALF_TURN      = PROD_W'(1) << (TURN_SHIFT - 1);

   typedef enum logic [2:0] {
      CSR_TARGET_X         = 3'd0,
      CSR_TARGET_Y         = 3'd1,
      CSR_TARGET_Z         = 3'd2,
      CSR_WAVES_PER_METRE  = 3'd3,
      CSR_TWIN_TRAP        = 3'd4,
      CSR_TRANSDUCER_COUNT = 3'd5,
      CSR_AMPLITUDE_LEVEL  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
      logic [WAVES_W-1:0]        waves_per_metre;
      logic                      twin_trap;
      logic [COUNT_W-1:0]        transducer_count;
      logic [AMP_W-1:0]          amplitude_level;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               half_turn;
   } tag_type;

endpackage

// ===== rtl/fpg_dist.sv =====
`timescale 1ns / 1ps

module fpg_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  fpg_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   input  logic [fpg_pkg::INDEX_W-1:0]         in_index,
   input  logic signed [fpg_pkg::COORD_W-1:0]  in_pos_x,
   input  logic signed [fpg_pkg::COORD_W-1:0]  in_pos_y,
   input  logic signed [fpg_pkg::COORD_W-1:0]  in_pos_z,
   output logic                                out_valid,
   output logic [fpg_pkg::SUM_W-1:0]           out_sum,
   output fpg_pkg::tag_type                    out_tag
);
   import fpg_pkg::*;

   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic [COUNT_W-1:0]       count_sat;
   logic [COUNT_W-1:0]       half_count;

   logic [COORD_W-1:0] mx_ff, my_ff, mz_ff, mx_in, my_in, mz_in;
   logic [SQ_W-1:0]    sx_ff, sy_ff, sz_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [2:0]         vld_ff;
   tag_type            tag1_ff, tag1_in, tag2_ff, tag3_ff;

   always_comb begin
      dx = DIFF_W'(in_pos_x) - DIFF_W'(cfg.target_x);
      dy = DIFF_W'(in_pos_y) - DIFF_W'(cfg.target_y);
      dz = DIFF_W'(in_pos_z) - DIFF_W'(cfg.target_z);
      mx_in = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
      my_in = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
      mz_in = dz[DIFF_W-1] ? COORD_W'(-dz) : COORD_W'(dz);
      count_sat = (cfg.transducer_count > COUNT_LIMIT) ? COUNT_LIMIT : cfg.transducer_count;
      half_count = count_sat >> 1;
      tag1_in.index = in_index;
      tag1_in.half_turn = cfg.twin_trap && (COUNT_W'(in_index) >= half_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
      tag1_ff <= tag1_in;
      sx_ff   <= mx_ff * mx_ff;
      sy_ff   <= my_ff * my_ff;
      sz_ff   <= mz_ff * mz_ff;
      tag2_ff <= tag1_ff;
      sum_ff  <= SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
      tag3_ff <= tag2_ff;
   end

   assign out_valid = vld_ff[2];
   assign out_sum   = sum_ff;
   assign out_tag   = tag3_ff;

endmodule

// ===== rtl/fpg_sqrt.sv =====
`timescale 1ns / 1ps

module fpg_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [fpg_pkg::SUM_W-1:0]    in_radicand,
   input  fpg_pkg::tag_type             in_tag,
   output logic                         out_valid,
   output logic [fpg_pkg::ROOT_W-1:0]   out_root,
   output fpg_pkg::tag_type             out_tag
);
   import fpg_pkg::*;

   logic [ROOT_W-1:0] vld_ff, vld_src;
   logic [SUM_W-1:0]  rad_ff  [ROOT_W];
   logic [SUM_W-1:0]  rad_src [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_src [ROOT_W];
   logic [REM_W-1:0]  rem_in  [ROOT_W];
   logic [REM_W-1:0]  rem_sh  [ROOT_W];
   logic [REM_W-1:0]  trial   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_src [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];
   tag_type           tag_ff  [ROOT_W];
   tag_type           tag_src [ROOT_W];

   always_comb begin
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            vld_src[s]  = in_valid;
            rad_src[s]  = in_radicand;
            rem_src[s]  = '0;
            root_src[s] = '0;
            tag_src[s]  = in_tag;
         end else begin
            vld_src[s]  = vld_ff[s-1];
            rad_src[s]  = rad_ff[s-1];
            rem_src[s]  = rem_ff[s-1];
            root_src[s] = root_ff[s-1];
            tag_src[s]  = tag_ff[s-1];
         end
         rem_sh[s] = {rem_src[s][REM_W-3:0], rad_src[s][2*(ROOT_W-1-s) +: 2]};
         trial[s]  = REM_W'({root_src[s], 2'b01});
         if (rem_sh[s] >= trial[s]) begin
            rem_in[s]  = rem_sh[s] - trial[s];
            root_in[s] = {root_src[s][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_sh[s];
            root_in[s] = {root_src[s][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_src;
      end
      for (int s = 0; s < ROOT_W; s++) begin
         rad_ff[s]  <= rad_src[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         tag_ff[s]  <= tag_src[s];
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// ===== rtl/fpg_phase.sv =====
`timescale 1ns / 1ps

module fpg_phase (
   input  logic                               clock,
   input  logic                               reset,
   input  fpg_pkg::cfg_type                   cfg,
   input  logic                               in_valid,
   input  logic [fpg_pkg::ROOT_W-1:0]         in_root,
   input  fpg_pkg::tag_type                   in_tag,
   output logic                               out_valid,
   output logic [fpg_pkg::INDEX_W-1:0]        out_index,
   output logic signed [fpg_pkg::PHASE_W-1:0] out_phase,
   output logic [fpg_pkg::AMP_W-1:0]          out_amplitude
);
   import fpg_pkg::*;

   logic                      prod_vld_ff;
   logic [PROD_W-1:0]         prod_ff;
   tag_type                   prod_tag_ff;
   logic [PROD_W-1:0]         half;
   logic [PROD_W-1:0]         mag;
   logic                      neg;
   logic [PHASE_W-1:0]        frac;
   logic signed [PHASE_W-1:0] phase_in;
   logic [AMP_W-1:0]          amp_in;

   logic                      out_vld_ff;
   logic [INDEX_W-1:0]        out_index_ff;
   logic signed [PHASE_W-1:0] out_phase_ff;
   logic [AMP_W-1:0]          out_amp_ff;

   always_comb begin
      half = prod_tag_ff.half_turn ? HALF_TURN : '0;
      neg  = prod_ff > half;
      mag  = neg ? (prod_ff - half) : (half - prod_ff);
      frac = PHASE_W'(mag[TURN_SHIFT-1:FRAC_SHIFT]);
      phase_in = neg ? -$signed(frac) : $signed(frac);
      amp_in = (cfg.amplitude_level > FULL_AMPLITUDE) ? FULL_AMPLITUDE : cfg.amplitude_level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= in_valid;
         out_vld_ff  <= prod_vld_ff;
      end
      prod_ff      <= PROD_W'(cfg.waves_per_metre) * PROD_W'(in_root);
      prod_tag_ff  <= in_tag;
      out_index_ff <= prod_tag_ff.index;
      out_phase_ff <= phase_in;
      out_amp_ff   <= amp_in;
   end

   assign out_valid     = out_vld_ff;
   assign out_index     = out_index_ff;
   assign out_phase     = out_phase_ff;
   assign out_amplitude = out_amp_ff;

endmodule

// ===== rtl/focus_phase_generator_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         start & !busy         transducer_index, pos_x, pos_y, pos_z
// rsp       out        rsp_valid (1 cycle)   out_index, phase_turns, drive_amplitude
// csr       in         csr_write_enable      csr_index, csr_write_data
//
// One transaction per cycle; each accepted transaction passes through the stages
// (3 distance stages, 25 square-root stages, multiply, output register).
// Latency is set by the one-bit-per-stage square-root pipeline.
// Synchronous reset clears all valid bits and loads register defaults;
// busy is high only during reset. The receiver cannot stall, so the
// pipeline advances every cycle.
module focus_phase_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fpg_pkg::INDEX_W-1:0]         req_transducer_index,
   input  logic signed [fpg_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [fpg_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [fpg_pkg::COORD_W-1:0]  req_pos_z,
   output logic                                rsp_valid,
   output logic [fpg_pkg::INDEX_W-1:0]         rsp_out_index,
   output logic signed [fpg_pkg::PHASE_W-1:0]  rsp_phase_turns,
   output logic [fpg_pkg::AMP_W-1:0]           rsp_drive_amplitude,
   input  logic                                csr_write_enable,
   input  fpg_pkg::csr_index_type              csr_index,
   input  logic [fpg_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import fpg_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               accept;
   logic               dist_valid;
   logic [SUM_W-1:0]   dist_sum;
   tag_type            dist_tag;
   logic               root_valid;
   logic [ROOT_W-1:0]  root_value;
   tag_type            root_tag;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_X:         cfg_in.target_x = COORD_W'(csr_write_data);
            CSR_TARGET_Y:         cfg_in.target_y = COORD_W'(csr_write_data);
            CSR_TARGET_Z:         cfg_in.target_z = COORD_W'(csr_write_data);
            CSR_WAVES_PER_METRE:  cfg_in.waves_per_metre = WAVES_W'(csr_write_data);
            CSR_TWIN_TRAP:        cfg_in.twin_trap = csr_write_data[0];
            CSR_TRANSDUCER_COUNT: cfg_in.transducer_count = COUNT_W'(csr_write_data);
            CSR_AMPLITUDE_LEVEL:  cfg_in.amplitude_level = AMP_W'(csr_write_data);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_x         <= COORD_W'(0);
         cfg_ff.target_y         <= COORD_W'(0);
         cfg_ff.target_z         <= COORD_W'(83886);
         cfg_ff.waves_per_metre  <= WAVES_W'(7642808);
         cfg_ff.twin_trap        <= 1'b0;
         cfg_ff.transducer_count <= COUNT_W'(64);
         cfg_ff.amplitude_level  <= FULL_AMPLITUDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fpg_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .in_index  (req_transducer_index),
      .in_pos_x  (req_pos_x),
      .in_pos_y  (req_pos_y),
      .in_pos_z  (req_pos_z),
      .out_valid (dist_valid),
      .out_sum   (dist_sum),
      .out_tag   (dist_tag)
   );

   fpg_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dist_valid),
      .in_radicand (dist_sum),
      .in_tag      (dist_tag),
      .out_valid   (root_valid),
      .out_root    (root_value),
      .out_tag     (root_tag)
   );

   fpg_phase u_phase (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (root_valid),
      .in_root       (root_value),
      .in_tag        (root_tag),
      .out_valid     (rsp_valid),
      .out_index     (rsp_out_index),
      .out_phase     (rsp_phase_turns),
      .out_amplitude (rsp_drive_amplitude)
   );

`ifndef SYNTHESIS
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted transaction produced no result");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_LATENCY))
      else $error("result without a matching transaction");

   a_index_carry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_index == $past(req_transducer_index, PIPE_LATENCY))
      else $error("result index does not match its transaction");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase_turns != -(PHASE_W'(65536)))
      else $error("phase outside one turn");

   a_amp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_amplitude <= FULL_AMPLITUDE)
      else $error("amplitude above full scale");
`endif

endmodule

// ===== verif/focus_phase_generator_top_tb.sv =====
`timescale 1ns / 1ps

module focus_phase_generator_top_tb;
   import fpg_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_ITEMS = 830;
   localparam int          PLAN_LEN     = 36;
   localparam logic [23:0] COORD_MAX    = 24'h7FFFFF;
   localparam logic [23:0] COORD_MIN    = 24'h800000;
   localparam logic [16:0] HALF_PHASE   = 17'd32768;
   localparam csr_index_type CSR_UNMAPPED = csr_index_type'(3'd7);

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [PHASE_W-1:0] phase;
      logic [AMP_W-1:0]   amplitude;
   } phase_result_type;

   typedef struct packed {
      logic                  is_write;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] data;
      logic [INDEX_W-1:0]    idx;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [COORD_W-1:0]    z;
      logic                  has_known;
      logic [PHASE_W-1:0]    phase;
      logic [AMP_W-1:0]      amp;
   } plan_row_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [INDEX_W-1:0]          req_transducer_index;
   logic signed [COORD_W-1:0]   req_pos_x;
   logic signed [COORD_W-1:0]   req_pos_y;
   logic signed [COORD_W-1:0]   req_pos_z;
   logic                        rsp_valid;
   logic [INDEX_W-1:0]          rsp_out_index;
   logic signed [PHASE_W-1:0]   rsp_phase_turns;
   logic [AMP_W-1:0]            rsp_drive_amplitude;
   logic                        csr_write_enable;
   csr_index_type               csr_index;
   logic [CSR_DATA_W-1:0]       csr_write_data;

   cfg_type          active_cfg;
   phase_result_type pending_results[$];
   plan_row_type     directed_plan [0:PLAN_LEN-1];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               burst_left = 0;

   focus_phase_generator_top u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_transducer_index (req_transducer_index),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_pos_z            (req_pos_z),
      .rsp_valid            (rsp_valid),
      .rsp_out_index        (rsp_out_index),
      .rsp_phase_turns      (rsp_phase_turns),
      .rsp_drive_amplitude  (rsp_drive_amplitude),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] axis_square(input logic signed [COORD_W-1:0] p,
                                               input logic signed [COORD_W-1:0] t);
      longint d;
      d = longint'(p) - longint'(t);
      return 64'(d * d);
   endfunction

   function automatic phase_result_type predict_phase(input logic [INDEX_W-1:0] idx,
                                                      input logic signed [COORD_W-1:0] px,
                                                      input logic signed [COORD_W-1:0] py,
                                                      input logic signed [COORD_W-1:0] pz);
      logic [63:0]        sq;
      logic [63:0]        root;
      logic [63:0]        trial;
      logic [63:0]        prod;
      logic [63:0]        shift;
      logic [63:0]        mag;
      logic [COUNT_W-1:0] count;
      logic               neg;
      logic [15:0]        frac;
      phase_result_type   r;
      sq = axis_square(px, active_cfg.target_x) + axis_square(py, active_cfg.target_y)
         + axis_square(pz, active_cfg.target_z);
      root = 64'd0;
      for (int b = ROOT_W; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= sq) root = trial;
      end
      prod = 64'(active_cfg.waves_per_metre) * root;
      count = (active_cfg.transducer_count > COUNT_LIMIT) ? COUNT_LIMIT
                                                          : active_cfg.transducer_count;
      shift = (active_cfg.twin_trap && idx >= (count >> 1)) ? (64'd1 << (TURN_SHIFT - 1))
                                                            : 64'd0;
      if (prod > shift) begin
         neg = 1'b1;
         mag = prod - shift;
      end else begin
         neg = 1'b0;
         mag = shift - prod;
      end
      frac = mag[TURN_SHIFT-1:FRAC_SHIFT];
      r.index = idx;
      r.phase = neg ? -{1'b0, frac} : {1'b0, frac};
      r.amplitude = (active_cfg.amplitude_level > FULL_AMPLITUDE) ? FULL_AMPLITUDE
                                                                  : active_cfg.amplitude_level;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input csr_index_type sel,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = '0;
      r.is_write = 1'b1;
      r.sel = sel;
      r.data = data;
      return r;
   endfunction

   function automatic plan_row_type item_row(input logic [INDEX_W-1:0] idx,
                                             input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y,
                                             input logic [COORD_W-1:0] z);
      plan_row_type r;
      r = '0;
      r.sel = CSR_TARGET_X;
      r.idx = idx;
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [INDEX_W-1:0] idx,
                                              input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] z,
                                              input logic [PHASE_W-1:0] phase,
                                              input logic [AMP_W-1:0] amp);
      plan_row_type r;
      r = item_row(idx, x, y, z);
      r.has_known = 1'b1;
      r.phase = phase;
      r.amp = amp;
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] small_offset();
      logic signed [COORD_W-1:0] v;
      v = COORD_W'($urandom());
      return v >>> $urandom_range(2, 23);
   endfunction

   function automatic logic [COORD_W-1:0] pick_target();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return '0;
         default: return COORD_W'($urandom());
      endcase
   endfunction

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 7);
         burst_left = $urandom_range(0, 30);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_transducer(input plan_row_type row);
      phase_result_type r;
      req_transducer_index <= row.idx;
      req_pos_x <= row.x;
      req_pos_y <= row.y;
      req_pos_z <= row.z;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (row.has_known) begin
         r.index = row.idx;
         r.phase = row.phase;
         r.amplitude = row.amp;
      end else begin
         r = predict_phase(row.idx, row.x, row.y, row.z);
      end
      pending_results.push_back(r);
      pace_sender();
   endtask

   task automatic write_register(input csr_index_type sel, input logic [CSR_DATA_W-1:0] data);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      @(posedge clock);
      case (sel)
         CSR_TARGET_X:         active_cfg.target_x = data[COORD_W-1:0];
         CSR_TARGET_Y:         active_cfg.target_y = data[COORD_W-1:0];
         CSR_TARGET_Z:         active_cfg.target_z = data[COORD_W-1:0];
         CSR_WAVES_PER_METRE:  active_cfg.waves_per_metre = data[WAVES_W-1:0];
         CSR_TWIN_TRAP:        active_cfg.twin_trap = data[0];
         CSR_TRANSDUCER_COUNT: active_cfg.transducer_count = data[COUNT_W-1:0];
         CSR_AMPLITUDE_LEVEL:  active_cfg.amplitude_level = data[AMP_W-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic randomize_setup();
      logic [CSR_DATA_W-1:0] v;
      write_register(CSR_TARGET_X, {8'($urandom()), pick_target()});
      write_register(CSR_TARGET_Y, {8'($urandom()), pick_target()});
      write_register(CSR_TARGET_Z, {8'($urandom()), pick_target()});
      case ($urandom_range(0, 5))
         0: v = '0;
         1: v = '1;
         2: v = 32'd7642808;
         3: v = $urandom_range(1, 32'hFFFFF);
         default: v = $urandom();
      endcase
      write_register(CSR_WAVES_PER_METRE, v);
      write_register(CSR_TWIN_TRAP, {31'($urandom()), 1'($urandom())});
      case ($urandom_range(0, 6))
         0: v = 0;
         1: v = 1;
         2: v = 2;
         3: v = 512;
         4: v = 1023;
         5: v = $urandom_range(513, 1023);
         default: v = $urandom_range(3, 511);
      endcase
      write_register(CSR_TRANSDUCER_COUNT, {22'($urandom()), v[COUNT_W-1:0]});
      if ($urandom_range(0, 3) == 0) write_register(CSR_UNMAPPED, $urandom());
      case ($urandom_range(0, 4))
         0: v = 0;
         1: v = 65536;
         2: v = $urandom_range(65537, 131071);
         default: v = $urandom_range(0, 65536);
      endcase
      write_register(CSR_AMPLITUDE_LEVEL, {15'($urandom()), v[AMP_W-1:0]});
   endtask

   always @(posedge clock) begin
      phase_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected transaction: out_index %0d phase_turns %0d", rsp_out_index,
                   rsp_phase_turns);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_index !== want.index) begin
               $error("out_index mismatch: expected %0d, actual %0d", want.index,
                      rsp_out_index);
               mismatch_count++;
            end
            if (rsp_phase_turns !== want.phase) begin
               $error("phase_turns mismatch: expected %0d, actual %0d", $signed(want.phase),
                      rsp_phase_turns);
               mismatch_count++;
            end
            if (rsp_drive_amplitude !== want.amplitude) begin
               $error("drive_amplitude mismatch: expected %0d, actual %0d", want.amplitude,
                      rsp_drive_amplitude);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      plan_row_type          row;
      logic [COUNT_W-1:0]    count;
      logic [INDEX_W-1:0]    idx;
      logic [COORD_W-1:0]    px;
      logic [COORD_W-1:0]    py;
      logic [COORD_W-1:0]    pz;
      int                    random_sent;
      int                    phase_items;

      reset <= 1'b1;
      start <= 1'b0;
      req_transducer_index <= '0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_TARGET_X;
      csr_write_data <= '0;

      active_cfg.target_x = '0;
      active_cfg.target_y = '0;
      active_cfg.target_z = 24'd83886;
      active_cfg.waves_per_metre = 32'd7642808;
      active_cfg.twin_trap = 1'b0;
      active_cfg.transducer_count = 10'd64;
      active_cfg.amplitude_level = FULL_AMPLITUDE;

      directed_plan = '{
         known_row(9'd0, 24'd0, 24'd0, 24'd83886, 17'd0, FULL_AMPLITUDE),
         item_row(9'd511, 24'd0, 24'd0, 24'd0),
         item_row(9'd5, COORD_MAX, COORD_MAX, COORD_MAX),
         item_row(9'd300, COORD_MIN, COORD_MIN, COORD_MIN),
         item_row(9'h155, 24'h555555, 24'hAAAAAA, 24'h0F0F0F),
         csr_row(CSR_TARGET_X, 32'hFF7FFFFF),
         csr_row(CSR_TARGET_Y, 32'h5A800000),
         csr_row(CSR_TARGET_Z, 32'h12000000),
         item_row(9'h0AA, COORD_MIN, COORD_MAX, COORD_MAX),
         known_row(9'd1, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         csr_row(CSR_TWIN_TRAP, 32'hFFFFFFFF),
         known_row(9'd31, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         known_row(9'd32, COORD_MAX, COORD_MIN, 24'd0, HALF_PHASE, FULL_AMPLITUDE),
         item_row(9'd100, 24'd0, 24'd0, 24'd0),
         csr_row(CSR_WAVES_PER_METRE, 32'd0),
         known_row(9'd511, COORD_MIN, COORD_MAX, COORD_MIN, HALF_PHASE, FULL_AMPLITUDE),
         known_row(9'd0, 24'h123456, 24'h654321, 24'hFEDCBA, 17'd0, FULL_AMPLITUDE),
         csr_row(CSR_WAVES_PER_METRE, 32'hFFFFFFFF),
         item_row(9'd400, COORD_MIN, COORD_MAX, COORD_MAX),
         item_row(9'd2, 24'h7FFFFE, COORD_MIN, 24'h000001),
         csr_row(CSR_TRANSDUCER_COUNT, 32'd0),
         known_row(9'd0, COORD_MAX, COORD_MIN, 24'd0, HALF_PHASE, FULL_AMPLITUDE),
         csr_row(CSR_TRANSDUCER_COUNT, 32'hFFFFFFFF),
         known_row(9'd255, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         known_row(9'd256, COORD_MAX, COORD_MIN, 24'd0, HALF_PHASE, FULL_AMPLITUDE),
         csr_row(CSR_AMPLITUDE_LEVEL, 32'hFFFFFFFF),
         known_row(9'd7, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         csr_row(CSR_UNMAPPED, 32'd0),
         known_row(9'd8, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         csr_row(CSR_AMPLITUDE_LEVEL, 32'd0),
         known_row(9'd9, COORD_MAX, COORD_MIN, 24'd0, 17'd0, 17'd0),
         csr_row(CSR_AMPLITUDE_LEVEL, 32'd65537),
         known_row(9'd10, COORD_MAX, COORD_MIN, 24'd0, 17'd0, FULL_AMPLITUDE),
         csr_row(CSR_AMPLITUDE_LEVEL, 32'd12345),
         item_row(9'd511, 24'd0, 24'd0, 24'd0),
         item_row(9'd300, 24'h000100, 24'hFFFF00, 24'h7FFF00)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write) write_register(directed_plan[i].sel, directed_plan[i].data);
         else send_transducer(directed_plan[i]);
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         randomize_setup();
         phase_items = $urandom_range(30, 110);
         if (phase_items > RANDOM_ITEMS - random_sent) phase_items = RANDOM_ITEMS - random_sent;
         repeat (phase_items) begin
            count = (active_cfg.transducer_count > COUNT_LIMIT) ? COUNT_LIMIT
                                                                : active_cfg.transducer_count;
            if ($urandom_range(0, 3) == 0)
               idx = INDEX_W'(int'(count >> 1) + $urandom_range(0, 4) - 2);
            else
               idx = INDEX_W'($urandom());
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  px = active_cfg.target_x + small_offset();
                  py = active_cfg.target_y + small_offset();
                  pz = active_cfg.target_z + small_offset();
               end
               6, 7: begin
                  px = COORD_W'($urandom());
                  py = COORD_W'($urandom());
                  pz = COORD_W'($urandom());
               end
               8: begin
                  px = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                  py = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                  pz = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               end
               default: begin
                  px = active_cfg.target_x;
                  py = active_cfg.target_y;
                  pz = active_cfg.target_z;
               end
            endcase
            row = item_row(idx, px, py, pz);
            send_transducer(row);
            random_sent++;
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
